FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque unit
// Command codes, result status codes and the per-cell shift operation.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int CMD_BITS    = 4;
	localparam int STATUS_BITS = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_PUSH_TAIL = 4'd0,
		CMD_PUSH_HEAD = 4'd1,
		CMD_POP_HEAD  = 4'd2,
		CMD_POP_TAIL  = 4'd3,
		CMD_PEEK_HEAD = 4'd4,
		CMD_PEEK_TAIL = 4'd5,
		CMD_READ_AT   = 4'd6,
		CMD_INSERT_AT = 4'd7,
		CMD_REMOVE_AT = 4'd8,
		CMD_CLEAR     = 4'd9
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// what every cell does with its word
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,	// cells above k take left neighbor, cell k takes din
		CELL_DEL  = 2'd2	// cells at and above k take right neighbor
	} cell_op_t;

endpackage

FILE: sv/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell: one entry of the deque row
// Holds the word at one logical position; shifts with its neighbors.
// ----------------------------------------------------------------------------
module cdq_cell
	import cdq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int AW  = 6,
	parameter int WB  = 32
) (
	input  logic          clk,
	input  cell_op_t      op,
	input  logic [AW-1:0] k,
	input  logic [WB-1:0] din,
	input  logic [WB-1:0] left,
	input  logic [WB-1:0] right,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_idx,
	output logic [WB-1:0] data,
	output logic [WB-1:0] rd_data
);

	localparam logic [AW-1:0] MY = AW'(IDX);

	logic [WB-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INS: begin
				if (MY > k) begin
					data_q <= left;
				end else if (MY == k) begin
					data_q <= din;
				end
			end
			CELL_DEL: begin
				if (MY >= k) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	// zero unless selected, so the row can be OR-reduced
	assign rd_data = (rd_en && (rd_idx == MY)) ? data_q : '0;

endmodule

FILE: sv/circular_deque_with_positional_ops_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_with_positional_ops_unit: double-ended queue with
// positional insert, remove and read
// Row of DEPTH cells kept in logical order, head in cell 0.
// ----------------------------------------------------------------------------
// Each input transfer carries one command and yields exactly one output
// transfer {data_out, status, occupancy}. Entries are stored in a row of
// cells in logical order (cell 0 is the head), so every push, head pop, insert
// and remove is a parallel shift of the row, and a tail pop only lowers the
// count; no ring pointers are needed. Reads (pop, peek, read_at, remove_at)
// select one cell and OR-reduce the row in two registered levels (groups of
// eight cells, then the groups): the first level is loaded at the accept edge,
// the second when the result moves into the output register; that move waits
// while an earlier result is still stalled there. A new command
// is accepted every cycle as long as results are drained; the state update
// of a command is complete at its accept edge, so back-to-back commands see
// each other's effect. A push or insert into a full queue answers "full" and
// changes nothing; read/remove need position < occupancy, insert needs
// position <= occupancy. Clear drops all entries. Unused command codes return
// status ok with no change. No reset sweep: cells hold no valid bits.
// ----------------------------------------------------------------------------
module circular_deque_with_positional_ops_unit
	import cdq_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [3:0] command, [CW+3:4] position, next WORD_BITS data_in, zero pad
	input  logic [((CMD_BITS + $clog2(DEPTH+1) + WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// [WORD_BITS-1:0] data_out, next 2 status, next CW occupancy, zero pad
	output logic [((WORD_BITS + STATUS_BITS + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int GRP      = 8;
	localparam int NGRP     = (DEPTH + GRP - 1) / GRP;
	localparam int OUT_BITS = WORD_BITS + STATUS_BITS + CW;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// input fields
	logic [CMD_BITS-1:0]  cmd_raw;
	logic [CW-1:0]        pos;
	logic [WORD_BITS-1:0] din;

	assign cmd_raw = s_tdata[CMD_BITS-1:0];
	assign pos     = s_tdata[CMD_BITS +: CW];
	assign din     = s_tdata[CMD_BITS + CW +: WORD_BITS];

	logic [CW-1:0] count_q;
	logic          accept;
	logic          advance;
	logic          busy_s1;

	// command decode
	logic          full, empty, pos_lt, pos_le;
	logic [AW-1:0] cnt_m1;
	cell_op_t      op_d, op;
	logic [AW-1:0] k_d;
	logic          rd_en_d;
	logic [AW-1:0] rd_idx_d;
	status_t       status_d;
	logic [CW-1:0] count_d;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign pos_lt = (pos < count_q);
	assign pos_le = (pos <= count_q);
	assign cnt_m1 = AW'(count_q - CW'(1));

	always_comb begin
		op_d     = CELL_HOLD;
		k_d      = '0;
		rd_en_d  = 1'b0;
		rd_idx_d = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (cmd_raw)
			CMD_PUSH_TAIL: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INS;
					k_d     = count_q[AW-1:0];
					count_d = count_q + CW'(1);
				end
			end
			CMD_PUSH_HEAD: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INS;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP_HEAD: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en_d = 1'b1;
					op_d    = CELL_DEL;
					count_d = count_q - CW'(1);
				end
			end
			CMD_POP_TAIL: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en_d  = 1'b1;
					rd_idx_d = cnt_m1;
					count_d  = count_q - CW'(1);
				end
			end
			CMD_PEEK_HEAD: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en_d = 1'b1;
				end
			end
			CMD_PEEK_TAIL: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en_d  = 1'b1;
					rd_idx_d = cnt_m1;
				end
			end
			CMD_READ_AT: begin
				if (!pos_lt) begin
					status_d = ST_BADPOS;
				end else begin
					rd_en_d  = 1'b1;
					rd_idx_d = pos[AW-1:0];
				end
			end
			CMD_INSERT_AT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (!pos_le) begin
					status_d = ST_BADPOS;
				end else begin
					op_d    = CELL_INS;
					k_d     = pos[AW-1:0];
					count_d = count_q + CW'(1);
				end
			end
			CMD_REMOVE_AT: begin
				if (!pos_lt) begin
					status_d = ST_BADPOS;
				end else begin
					rd_en_d  = 1'b1;
					rd_idx_d = pos[AW-1:0];
					op_d     = CELL_DEL;
					k_d      = pos[AW-1:0];
					count_d  = count_q - CW'(1);
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// handshake: one result in the reduce stage, one in the output register
	assign advance  = busy_s1 && (!m_tvalid || m_tready);
	assign s_tready = !busy_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign op       = accept ? op_d : CELL_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// cell row
	logic [WORD_BITS-1:0] cell_data [DEPTH];
	logic [WORD_BITS-1:0] cell_rd   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = din;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		cdq_cell #(
			.IDX (i),
			.AW  (AW),
			.WB  (WORD_BITS)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.k       (k_d),
			.din     (din),
			.left    (left_w),
			.right   (right_w),
			.rd_en   (rd_en_d),
			.rd_idx  (rd_idx_d),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	// read reduction, level one: OR within groups of eight cells
	logic [WORD_BITS-1:0] grp_d  [NGRP];
	logic [WORD_BITS-1:0] grp_s1 [NGRP];
	status_t              status_s1;
	logic [CW-1:0]        occ_s1;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < DEPTH) begin
					grp_d[g] = grp_d[g] | cell_rd[g * GRP + j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (advance) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1    <= grp_d;
			status_s1 <= status_d;
			occ_s1    <= count_d;
		end
	end

	// level two: OR the groups into the output register
	logic [WORD_BITS-1:0] dout_d;
	logic [WORD_BITS-1:0] dout_q;
	status_t              status_q;
	logic [CW-1:0]        occ_q;
	logic                 out_valid_q;

	always_comb begin
		dout_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			dout_d = dout_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dout_q   <= dout_d;
			status_q <= status_s1;
			occ_q    <= occ_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({occ_q, status_q, dout_q});

endmodule

FILE: sv/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks for the circular deque unit
// Result consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
module cdq_checker
	import cdq_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((WORD_BITS + STATUS_BITS + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [WORD_BITS-1:0]   dout;
	logic [STATUS_BITS-1:0] st;
	logic [CW-1:0]          occ;

	assign dout = m_tdata[WORD_BITS-1:0];
	assign st   = m_tdata[WORD_BITS +: STATUS_BITS];
	assign occ  = m_tdata[WORD_BITS + STATUS_BITS +: CW];

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ <= CW'(DEPTH))
		else $error("occupancy above capacity");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_FULL |-> occ == CW'(DEPTH))
		else $error("full status with room left");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_EMPTY |-> occ == '0)
		else $error("empty status with entries present");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_OK |-> dout == '0)
		else $error("failed command returned data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind circular_deque_with_positional_ops_unit cdq_checker #(
	.DEPTH     (DEPTH),
	.WORD_BITS (WORD_BITS)
) u_cdq_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for circular_deque_with_positional_ops_unit
// Drives deque commands over the input stream. A queue of words models the
// deque and predicts each result. The output stream is checked field by field.
// ----------------------------------------------------------------------------
// Test flow, one task per topic:
//   test_empty_queue   - every read-type command on an empty deque
//   test_basic_ops     - push/pop/peek at both ends, positional ops at the
//                        edges of the valid range, unused codes, clear
//   test_full_queue    - fill to capacity, every push/insert against full,
//                        then churn at the full boundary
//   test_backpressure  - receiver holds off for a long stretch while the
//                        sender keeps offering, so the unit stalls its input
//   test_random        - chunks biased to fill, drain or mix
//   test_no_idle       - final stretch with both sides streaming flat out
// The model is a logical-order queue. The unit keeps no ring pointers, and
// its cells are invisible from the ports, so only order and contents matter.
// ----------------------------------------------------------------------------
module tb_top;
	import cdq_pkg::*;

	localparam int DEPTH      = 64;
	localparam int WORD_BITS  = 32;
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int IN_W       = ((CMD_BITS + CW + WORD_BITS + 7) / 8) * 8;
	localparam int OUT_W      = ((WORD_BITS + STATUS_BITS + CW + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 300000;	// far above the slowest legal run
	localparam int LONG_HOLD  = 400;	// receiver hold-off for the pressure test
	localparam int DRAIN_WAIT = 10;		// two-stage read path, plus margin

	// unused command codes
	localparam logic [CMD_BITS-1:0] CMD_UNUSED_FIRST = 4'd10;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED_LAST  = 4'd15;

	// stream modes for random command selection
	localparam int MODE_MIXED = 0;
	localparam int MODE_FILL  = 1;
	localparam int MODE_DRAIN = 2;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		status_t              status;
		logic [CW-1:0]        occupancy;
	} deque_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;		// [3:0] command, [10:4] position, [42:11] data_in
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;		// [31:0] data_out, [33:32] status, [40:34] occupancy

	// model contents in logical order, head first
	logic [WORD_BITS-1:0] deque_words[$];
	// results predicted but not yet seen on the output
	deque_result_t        pending_results[$];

	int  error_count = 0;
	int  cycle_count = 0;
	bit  tx_gaps = 1'b0;		// sender idles in random bursts
	bit  rx_gaps = 1'b0;		// receiver stalls in random bursts
	bit  hold_request = 1'b0;	// ask receiver for one long hold-off
	int  hold_left = 0;
	int  stall_left = 0;

	circular_deque_with_positional_ops_unit #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
			input logic [WORD_BITS-1:0] want);
		$display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want,
			cycle_count);
		error_count++;
	endtask

	// Applies one command to the model deque and returns its result.
	function automatic deque_result_t deque_apply(input logic [CMD_BITS-1:0] code,
			input logic [CW-1:0] pos, input logic [WORD_BITS-1:0] din);
		deque_result_t r;
		int            n;
		n = deque_words.size();
		r.word = '0;
		r.status = ST_OK;
		case (code)
			CMD_PUSH_TAIL: begin
				if (n >= DEPTH) r.status = ST_FULL;
				else deque_words.push_back(din);
			end
			CMD_PUSH_HEAD: begin
				if (n >= DEPTH) r.status = ST_FULL;
				else deque_words.push_front(din);
			end
			CMD_POP_HEAD: begin
				if (n == 0) r.status = ST_EMPTY;
				else r.word = deque_words.pop_front();
			end
			CMD_POP_TAIL: begin
				if (n == 0) r.status = ST_EMPTY;
				else r.word = deque_words.pop_back();
			end
			CMD_PEEK_HEAD: begin
				if (n == 0) r.status = ST_EMPTY;
				else r.word = deque_words[0];
			end
			CMD_PEEK_TAIL: begin
				if (n == 0) r.status = ST_EMPTY;
				else r.word = deque_words[n-1];
			end
			CMD_READ_AT: begin
				if (int'(pos) >= n) r.status = ST_BADPOS;
				else r.word = deque_words[pos];
			end
			CMD_INSERT_AT: begin
				// full wins over a bad position
				if (n >= DEPTH) r.status = ST_FULL;
				else if (int'(pos) > n) r.status = ST_BADPOS;
				else deque_words.insert(pos, din);
			end
			CMD_REMOVE_AT: begin
				if (int'(pos) >= n) r.status = ST_BADPOS;
				else begin
					r.word = deque_words[pos];
					deque_words.delete(pos);
				end
			end
			CMD_CLEAR: deque_words.delete();
			default: ;	// unused codes: no change
		endcase
		r.occupancy = CW'(deque_words.size());
		return r;
	endfunction

	// Offers one command and blocks until the transfer completes.
	task automatic send_cmd(input logic [CMD_BITS-1:0] code, input logic [CW-1:0] pos,
			input logic [WORD_BITS-1:0] din);
		logic [IN_W-1:0] beat;
		beat = '0;
		beat[CMD_BITS-1:0] = code;
		beat[CMD_BITS +: CW] = pos;
		beat[CMD_BITS+CW +: WORD_BITS] = din;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(deque_apply(code, pos, din));
	endtask

	// Output side: one ready decision per cycle.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_gaps && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
			end
		end
	end

	// Result checker: each output transfer against the oldest prediction.
	always @(posedge clk) begin : check_results
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.word = m_tdata[WORD_BITS-1:0];
			got.status = status_t'(m_tdata[WORD_BITS +: STATUS_BITS]);
			got.occupancy = m_tdata[WORD_BITS+STATUS_BITS +: CW];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, data_out", got.word, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.word !== want.word)
					report_mismatch("data_out", got.word, want.word);
				if (got.status !== want.status)
					report_mismatch("status", WORD_BITS'(got.status), WORD_BITS'(want.status));
				if (got.occupancy !== want.occupancy)
					report_mismatch("occupancy", WORD_BITS'(got.occupancy),
						WORD_BITS'(want.occupancy));
			end
		end
	end

	function automatic logic [WORD_BITS-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly legal positions, with the boundary and the far range mixed in.
	function automatic logic [CW-1:0] rand_pos();
		int n;
		n = deque_words.size();
		case ($urandom_range(0, 9))
			0: return CW'($urandom_range(0, (1 << CW) - 1));
			1: return CW'(n);
			2: return '0;
			default: return CW'($urandom_range(0, n));
		endcase
	endfunction

	function automatic logic [CMD_BITS-1:0] pick_cmd(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == MODE_FILL) begin
			if (r < 40) return CMD_PUSH_TAIL;
			if (r < 65) return CMD_PUSH_HEAD;
			if (r < 82) return CMD_INSERT_AT;
		end else if (mode == MODE_DRAIN) begin
			if (r < 28) return CMD_POP_HEAD;
			if (r < 52) return CMD_POP_TAIL;
			if (r < 74) return CMD_REMOVE_AT;
		end
		r = $urandom_range(0, 99);
		if (r < 14) return CMD_PUSH_TAIL;
		if (r < 26) return CMD_PUSH_HEAD;
		if (r < 37) return CMD_POP_HEAD;
		if (r < 48) return CMD_POP_TAIL;
		if (r < 55) return CMD_PEEK_HEAD;
		if (r < 62) return CMD_PEEK_TAIL;
		if (r < 74) return CMD_READ_AT;
		if (r < 86) return CMD_INSERT_AT;
		if (r < 97) return CMD_REMOVE_AT;
		if (r < 98) return CMD_CLEAR;
		return CMD_BITS'($urandom_range(int'(CMD_UNUSED_FIRST), int'(CMD_UNUSED_LAST)));
	endfunction

	task automatic send_random(input int count, input int mode);
		repeat (count) send_cmd(pick_cmd(mode), rand_pos(), rand_word());
	endtask

	task automatic test_empty_queue();
		send_cmd(CMD_POP_HEAD, '0, '1);
		send_cmd(CMD_POP_TAIL, '0, '1);
		send_cmd(CMD_PEEK_HEAD, '0, '0);
		send_cmd(CMD_PEEK_TAIL, '0, '0);
		send_cmd(CMD_READ_AT, '0, '0);
		send_cmd(CMD_REMOVE_AT, '0, '0);
		send_cmd(CMD_INSERT_AT, CW'(1), 32'h1234_5678);	// past end of empty deque
	endtask

	task automatic test_basic_ops();
		send_cmd(CMD_PUSH_TAIL, '0, '1);
		send_cmd(CMD_PUSH_HEAD, '1, '0);
		send_cmd(CMD_INSERT_AT, CW'(1), 32'hA5A5_5A5A);
		send_cmd(CMD_INSERT_AT, CW'(3), 32'h0F0F_F0F0);	// append at tail
		send_cmd(CMD_INSERT_AT, CW'(5), 32'hDEAD_BEEF);	// above the count
		send_cmd(CMD_READ_AT, CW'(0), '0);
		send_cmd(CMD_READ_AT, CW'(3), '0);
		send_cmd(CMD_READ_AT, CW'(4), '0);		// equal to the count
		send_cmd(CMD_READ_AT, '1, '0);
		send_cmd(CMD_PEEK_HEAD, '0, '0);
		send_cmd(CMD_PEEK_TAIL, '0, '0);
		send_cmd(CMD_REMOVE_AT, CW'(1), '0);
		send_cmd(CMD_REMOVE_AT, CW'(3), '0);		// equal to the count
		send_cmd(CMD_UNUSED_FIRST, '0, '1);
		send_cmd(CMD_UNUSED_LAST, '1, '1);
		send_cmd(CMD_POP_TAIL, '0, '0);
		send_cmd(CMD_POP_HEAD, '0, '0);
		send_cmd(CMD_PUSH_TAIL, '0, 32'h8000_0001);
		send_cmd(CMD_CLEAR, '0, '0);
	endtask

	task automatic test_full_queue();
		while (deque_words.size() < DEPTH) send_cmd(CMD_PUSH_TAIL, rand_pos(), $urandom());
		send_cmd(CMD_PUSH_TAIL, '0, '1);
		send_cmd(CMD_PUSH_HEAD, '0, '1);
		send_cmd(CMD_INSERT_AT, '0, '1);
		send_cmd(CMD_INSERT_AT, '1, '1);		// full reported before bad position
		send_cmd(CMD_READ_AT, CW'(DEPTH - 1), '0);
		send_cmd(CMD_READ_AT, CW'(DEPTH), '0);
		send_cmd(CMD_REMOVE_AT, CW'(DEPTH - 1), '0);
		send_cmd(CMD_INSERT_AT, CW'(DEPTH - 1), 32'h5555_AAAA);
		send_cmd(CMD_REMOVE_AT, '0, '0);
		send_cmd(CMD_INSERT_AT, '0, 32'hAAAA_5555);
		send_random(40, MODE_FILL);
		send_random(80, MODE_DRAIN);
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		send_random(60, MODE_MIXED);
	endtask

	task automatic test_random(input int total);
		int done_count;
		int chunk;
		int mode;
		done_count = 0;
		mode = MODE_FILL;
		while (done_count < total) begin
			chunk = $urandom_range(40, 120);
			send_random(chunk, mode);
			done_count += chunk;
			// walk fill -> mixed -> drain or fill, and drain -> fill
			case (mode)
				MODE_FILL:  mode = MODE_MIXED;
				MODE_DRAIN: mode = MODE_FILL;
				default:    mode = ($urandom_range(0, 1) != 0) ? MODE_DRAIN : MODE_FILL;
			endcase
			// stretches with and without idling on each side
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
		end
	endtask

	task automatic test_no_idle();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_random(60, MODE_FILL);
		send_random(100, MODE_MIXED);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		test_basic_ops();
		test_full_queue();
		test_backpressure();
		test_random(870);
		test_no_idle();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
